@@ rtl/bpa_pkg.sv @@
// Package for the bitmap page allocator: field widths, reset values,
// status and operation codes, controller states and the bit search helper.
// No dependencies; every file of the block but bpa_bitmap_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

  // Fixed field widths
  localparam int ADDR_W     = 32;
  localparam int COUNT_W    = 13;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Bitmap word organization
  localparam int WORD_BITS = 32;
  localparam int BIT_IDX_W = 5;

  // Parameter defaults
  localparam int DEF_MAX_PAGES  = 4096;
  localparam int DEF_PAGE_SHIFT = 12;

  // Register reset values
  localparam logic [ADDR_W-1:0]  RESET_BASE  = 32'h0030_0000;
  localparam logic [COUNT_W-1:0] RESET_COUNT = 13'd4096;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_MEM    = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_t;

  typedef enum logic {
    REG_BASE  = 1'b0,
    REG_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_PUSH
  } fsm_t;

  // Configuration seen by the controller
  typedef struct packed {
    logic [ADDR_W-1:0]  base_address;
    logic [COUNT_W-1:0] page_count;
  } cfg_t;

  // Position of the lowest set bit of a word (0 when the word is zero)
  function automatic logic [BIT_IDX_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bpa_if.sv @@
// Valid/ready channels of the bitmap page allocator: request and response.
// Depends on bpa_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface bpa_req_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  op_t               operation;
  logic [ADDR_W-1:0] page_address;

  modport source (output valid, operation, page_address, input ready);
  modport sink   (input valid, operation, page_address, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
  logic               valid;
  logic               ready;
  status_t            status;
  logic [ADDR_W-1:0]  granted_address;
  logic [COUNT_W-1:0] used_pages;

  modport source (output valid, status, granted_address, used_pages, input ready);
  modport sink   (input valid, status, granted_address, used_pages, output ready);
endinterface

`default_nettype wire

@@ rtl/bpa_bitmap_ram.sv @@
// Bitmap storage: simple dual-port synchronous RAM, one write and one read
// port, registered read data. Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module bpa_bitmap_ram #(
  parameter int DEPTH  = 128,
  parameter int AW     = 7,
  parameter int DW     = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] ram_r [DEPTH];
  logic [DW-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) ram_r[waddr] <= wdata;
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) rdata_r <= ram_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/bpa_cfg_regs.sv @@
// APB register file of the page allocator: base address and page count.
// Depends on bpa_pkg for widths, register indexes and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module bpa_cfg_regs import bpa_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  reg_idx_t           sel;
  logic               wr_en;

  // Registers sit on 4-byte strides; address bit 2 picks one
  assign sel    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    base_nxt  = base_r;
    count_nxt = count_r;
    if (wr_en) begin
      unique case (sel)
        REG_BASE:  base_nxt  = pwdata;
        REG_COUNT: count_nxt = pwdata[COUNT_W-1:0];
        default:   base_nxt  = base_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= RESET_BASE;
      count_r <= RESET_COUNT;
    end else begin
      base_r  <= base_nxt;
      count_r <= count_nxt;
    end
  end

  // Read mux
  always_comb begin
    unique case (sel)
      REG_BASE:  prdata = base_r;
      REG_COUNT: prdata = CFG_DATA_W'(count_r);
      default:   prdata = '0;
    endcase
  end

  assign cfg.base_address = base_r;
  assign cfg.page_count   = count_r;

endmodule

`default_nettype wire

@@ rtl/bpa_ctrl.sv @@
// Allocator sequencer: clears the bitmap RAM after reset, then runs
// read-modify-write passes over bitmap words for allocate and free beats.
// Depends on bpa_pkg and the bpa_req_if / bpa_rsp_if channels.
`timescale 1ns / 1ps
`default_nettype none

module bpa_ctrl import bpa_pkg::*; #(
  parameter int MAX_PAGES  = DEF_MAX_PAGES,
  parameter int PAGE_SHIFT = DEF_PAGE_SHIFT,
  parameter int WORDS      = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS,
  parameter int WIDX_W     = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cfg_t                 cfg,
  bpa_req_if.sink                   req,
  bpa_rsp_if.source                 rsp,
  output logic                      mem_we,
  output logic     [WIDX_W-1:0]     mem_waddr,
  output logic     [WORD_BITS-1:0]  mem_wdata,
  output logic                      mem_re,
  output logic     [WIDX_W-1:0]     mem_raddr,
  input  wire logic [WORD_BITS-1:0] mem_rdata
);

  localparam int PIDX_W = WIDX_W + BIT_IDX_W;
  localparam int CNT_W  = $clog2(MAX_PAGES + 1);
  localparam int N_W    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int CMP_W  = N_W + 1;
  localparam int WIDE_W = ADDR_W + 1;

  fsm_t                st_r, st_nxt;
  op_t                 op_r, op_nxt;
  logic [WIDX_W-1:0]   widx_r, widx_nxt;
  logic [BIT_IDX_W-1:0] bit_r, bit_nxt;
  logic [WIDX_W-1:0]   hint_r, hint_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  // Output register and parked result
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]   out_granted_r, out_granted_nxt;
  logic [CNT_W-1:0]    out_used_r, out_used_nxt;
  status_t             pend_status_r, pend_status_nxt;
  logic [ADDR_W-1:0]   pend_granted_r, pend_granted_nxt;

  // Effective page count and free-address decode
  logic [N_W-1:0]      eff_n;
  logic [ADDR_W-1:0]   diff;
  logic                out_rng;
  logic [PIDX_W-1:0]   free_idx;

  // Word scan
  logic [CMP_W-1:0]    word_base;
  logic [CMP_W-1:0]    rem;
  logic [WORD_BITS-1:0] valid_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic                found;
  logic [BIT_IDX_W-1:0] hit_bit;
  logic [PIDX_W-1:0]   hit_idx;
  logic                last_word;

  // Commit of one result
  logic                commit;
  status_t             res_status;
  logic [ADDR_W-1:0]   res_granted;
  logic                slot_free;
  logic                alloc_hit;
  logic                free_hit;
  logic                accept;

  assign eff_n = (N_W'(cfg.page_count) > N_W'(MAX_PAGES)) ? N_W'(MAX_PAGES)
                                                          : N_W'(cfg.page_count);

  // Range check in page units: offset >> shift must stay below the count
  assign diff     = req.page_address - cfg.base_address;
  assign out_rng  = (req.page_address < cfg.base_address) ||
                    (WIDE_W'(diff >> PAGE_SHIFT) >= WIDE_W'(eff_n));
  assign free_idx = PIDX_W'(diff >> PAGE_SHIFT);

  // Bits of the current word that lie below the effective count
  assign word_base = CMP_W'(widx_r) << BIT_IDX_W;
  assign rem       = CMP_W'(eff_n) - word_base;
  always_comb begin
    if (CMP_W'(eff_n) <= word_base) valid_mask = '0;
    else if (rem >= CMP_W'(WORD_BITS)) valid_mask = '1;
    else valid_mask = (WORD_BITS'(1) << rem[BIT_IDX_W-1:0]) - WORD_BITS'(1);
  end

  assign free_bits = ~mem_rdata & valid_mask;
  assign found     = |free_bits;
  assign hit_bit   = first_set(free_bits);
  assign hit_idx   = {widx_r, hit_bit};
  assign last_word = (word_base + CMP_W'(WORD_BITS)) >= CMP_W'(eff_n);

  assign accept    = req.valid & req.ready;
  assign slot_free = !out_valid_r || rsp.ready;
  assign req.ready = (st_r == S_IDLE);

  // Sequencer: next state, RAM control and result
  always_comb begin
    st_nxt           = st_r;
    op_nxt           = op_r;
    widx_nxt         = widx_r;
    bit_nxt          = bit_r;
    hint_nxt         = hint_r;
    cnt_nxt          = cnt_r;
    pend_status_nxt  = pend_status_r;
    pend_granted_nxt = pend_granted_r;
    mem_we           = 1'b0;
    mem_waddr        = widx_r;
    mem_wdata        = '0;
    mem_re           = 1'b0;
    mem_raddr        = widx_r;
    commit           = 1'b0;
    res_status       = ST_OK;
    res_granted      = '0;
    alloc_hit        = 1'b0;
    free_hit         = 1'b0;

    unique case (st_r)
      // Zero one bitmap word per cycle
      S_CLEAR: begin
        mem_we = 1'b1;
        if (widx_r == WIDX_W'(WORDS - 1)) begin
          widx_nxt = '0;
          st_nxt   = S_IDLE;
        end else begin
          widx_nxt = widx_r + WIDX_W'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          op_nxt = req.operation;
          if (req.operation == OP_ALLOC) begin
            widx_nxt = hint_r;
            st_nxt   = S_READ;
          end else if (out_rng) begin
            commit     = 1'b1;
            res_status = ST_RANGE;
          end else begin
            widx_nxt = free_idx[PIDX_W-1:BIT_IDX_W];
            bit_nxt  = free_idx[BIT_IDX_W-1:0];
            st_nxt   = S_READ;
          end
        end
      end

      S_READ: begin
        mem_re = 1'b1;
        st_nxt = S_CHECK;
      end

      // Word is on the read port: modify, write back or step on
      S_CHECK: begin
        if (op_r == OP_ALLOC) begin
          if (found) begin
            alloc_hit   = 1'b1;
            mem_we      = 1'b1;
            mem_wdata   = mem_rdata | (WORD_BITS'(1) << hit_bit);
            cnt_nxt     = cnt_r + CNT_W'(1);
            hint_nxt    = widx_r;
            commit      = 1'b1;
            res_status  = ST_OK;
            res_granted = cfg.base_address + (ADDR_W'(hit_idx) << PAGE_SHIFT);
          end else if (last_word) begin
            commit     = 1'b1;
            res_status = ST_NO_MEM;
          end else begin
            widx_nxt  = widx_r + WIDX_W'(1);
            mem_re    = 1'b1;
            mem_raddr = widx_r + WIDX_W'(1);
          end
        end else begin
          commit = 1'b1;
          if (mem_rdata[bit_r]) begin
            free_hit   = 1'b1;
            mem_we     = 1'b1;
            mem_wdata  = mem_rdata & ~(WORD_BITS'(1) << bit_r);
            if (cnt_r != '0) cnt_nxt = cnt_r - CNT_W'(1);
            if (widx_r < hint_r) hint_nxt = widx_r;
            res_status = ST_OK;
          end else begin
            res_status = ST_NOT_ALLOC;
          end
        end
      end

      S_PUSH: begin
        if (slot_free) st_nxt = S_IDLE;
      end

      default: st_nxt = S_IDLE;
    endcase

    // Route a finished result to the output or park it
    if (commit) begin
      if (slot_free) begin
        st_nxt = S_IDLE;
      end else begin
        st_nxt           = S_PUSH;
        pend_status_nxt  = res_status;
        pend_granted_nxt = res_granted;
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    out_used_nxt    = out_used_r;
    if (rsp.ready) out_valid_nxt = 1'b0;
    if (commit && slot_free) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = res_status;
      out_granted_nxt = res_granted;
      out_used_nxt    = cnt_nxt;
    end else if (st_r == S_PUSH && slot_free) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = pend_status_r;
      out_granted_nxt = pend_granted_r;
      out_used_nxt    = cnt_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      widx_r      <= '0;
      hint_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      widx_r      <= widx_nxt;
      hint_r      <= hint_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r           <= op_nxt;
    bit_r          <= bit_nxt;
    pend_status_r  <= pend_status_nxt;
    pend_granted_r <= pend_granted_nxt;
    out_status_r   <= out_status_nxt;
    out_granted_r  <= out_granted_nxt;
    out_used_r     <= out_used_nxt;
  end

  assign rsp.valid           = out_valid_r;
  assign rsp.status          = out_status_r;
  assign rsp.granted_address = out_granted_r;
  assign rsp.used_pages      = COUNT_W'(out_used_r);

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(cnt_r) <= CNT_W'(MAX_PAGES))
    else $error("used page count above bitmap size");

  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_hit |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("allocate did not bump the used count");

  a_free_hint: assert property (@(posedge clk) disable iff (!rst_n)
    free_hit |=> hint_r <= $past(widx_r))
    else $error("scan hint skips a freed word");

  a_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> mem_waddr != mem_raddr)
    else $error("bitmap word read and written in one cycle");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_granted_r == '0)
    else $error("failed request carries a granted address");

endmodule

`default_nettype wire

@@ rtl/bitmap_page_allocator.sv @@
// Bitmap page frame allocator, one bit per page of 2**PAGE_SHIFT bytes held
// in a 32-bit-wide RAM. After reset the bitmap RAM is zeroed one word per
// cycle while in_req.ready stays low; APB writes are taken meanwhile. A free
// beat reads the bitmap word and, if the page's bit is set, clears it and
// writes the word back; an out-of-range free is answered straight from idle.
// An allocate beat reads bitmap words one per cycle through the RAM's single
// read port; the scan starts at a hint word below which every word is known
// full, and stops at the first free bit or after the last word in range. One
// request is in flight at a time; a result waiting on out_rsp does not block
// acceptance of the next request, but a further result that finds the output
// still full is parked and holds off new requests until it is sent.
// Depends on bpa_pkg, bpa_if, bpa_bitmap_ram, bpa_cfg_regs and bpa_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_allocator import bpa_pkg::*; #(
  parameter int MAX_PAGES  = DEF_MAX_PAGES,
  parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bpa_req_if.sink                    in_req,
  bpa_rsp_if.source                  out_rsp,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int WORDS  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  cfg_t                 cfg;
  logic                 mem_we;
  logic [WIDX_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [WIDX_W-1:0]    mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  bpa_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpa_bitmap_ram #(
    .DEPTH (WORDS),
    .AW    (WIDX_W),
    .DW    (WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bpa_ctrl #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .WORDS      (WORDS),
    .WIDX_W     (WIDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .req       (in_req),
    .rsp       (out_rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

`default_nettype wire
